>>> rtl/kci_pkg.sv
package kci_pkg;

    localparam int MAX_ENTRIES     = 256;
    localparam int ID_W            = $clog2(MAX_ENTRIES);
    localparam int CODE_LENGTH_MAX = 512;
    localparam int POS_W           = 9;
    localparam int FRAGMENT_DIM    = 16;
    localparam int VAL_W           = 4;
    localparam int MAX_K           = 8;
    localparam int LANES           = 64;
    localparam int GROUPS          = MAX_ENTRIES / LANES;
    localparam int GRP_W           = $clog2(GROUPS);
    localparam int CNT_W           = 10;
    localparam int Q_W             = 17;
    localparam int DVD_W           = CNT_W + 16;
    localparam int ADDR_W          = POS_W + VAL_W + GRP_W;

    typedef enum logic [0:0] {
        CFG_CODE_LENGTH     = 1'b0,
        CFG_NEIGHBOUR_COUNT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [ID_W-1:0]  id;
    } cell_ent_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] num;
        logic [CNT_W-1:0] den;
    } div_req_t;

endpackage

>>> rtl/keyframe_code_knn_index.sv
// Keyframe code index. Codes arrive one fragment per transaction (start while busy is low).
// After reset all 32768 words of the membership memory are swept clear with busy high; config
// writes are taken at any time and cfg_ready is always high. An add fragment that sets a
// memory bit does a read-modify-write of one 64-bit word. A present query fragment reads
// one memory word per lane group: the 256 match counters sit in a ring that turns by 64
// lanes per memory word read. After a query's last fragment the ring turns one entry per
// cycle through an 8-cell ranking chain, then k results follow, each real neighbour's
// distance coming from the bit-serial distance divider and each empty rank given directly.
// Results appear on result_valid for one cycle each and must be taken then.
module keyframe_code_knn_index (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [8:0]        fragment_index,
    input  logic signed [4:0] fragment_value,
    input  logic              last_fragment,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [9:0]        cfg_data,
    output logic              result_valid,
    output logic signed [8:0] entry_id,
    output logic [2:0]        rank,
    output logic [9:0]        match_count,
    output logic [16:0]       distance_q16,
    output logic [3:0]        found_count,
    output logic              status,
    output logic              last_result
);
    import kci_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADD_WR, S_Q_UPD, S_SEL, S_OUT, S_DIV
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              last_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [ID_W:0]     entry_count_reg;
    logic [9:0]        code_length_reg;
    logic [3:0]        nc_reg;
    logic [ID_W-1:0]   sel_id_reg;
    logic [3:0]        filled_reg;
    logic [2:0]        rank_reg;
    logic [3:0]        found_reg;

    logic              rv_reg;
    logic [8:0]        id_reg;
    logic [2:0]        rank_out_reg;
    logic [9:0]        cnt_out_reg;
    logic [16:0]       dist_reg;
    logic [3:0]        found_out_reg;
    logic              status_reg;
    logic              last_out_reg;

    logic [CNT_W-1:0]  cnt_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]  cnt_next [MAX_ENTRIES];

    logic [LANES-1:0]  mem [2**ADDR_W];
    logic [LANES-1:0]  mem_rd_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] mem_ra;
    logic [LANES-1:0]  mem_wd;

    logic [9:0]        len_eff;
    logic [3:0]        k_eff;
    logic              present;
    logic              full;
    logic              ins_en;
    logic              rank_hit;
    logic              rank_last;
    cell_ent_t         cand;
    cell_ent_t         cell_q [MAX_K];
    logic [MAX_K-1:0]  keep;
    cell_ent_t         cur;
    div_req_t          div_req;
    logic              div_done;
    logic [Q_W-1:0]    div_q;

    assign len_eff = (code_length_reg == 10'd0) ? 10'd1 :
                     (code_length_reg > 10'(CODE_LENGTH_MAX)) ? 10'(CODE_LENGTH_MAX) :
                     code_length_reg;
    assign k_eff   = (nc_reg == 4'd0) ? 4'd1 : (nc_reg > 4'(MAX_K)) ? 4'(MAX_K) : nc_reg;
    assign present = !fragment_value[4] && ({1'b0, fragment_index} < len_eff);
    assign full    = entry_count_reg[ID_W];
    assign busy    = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign cand.cnt = (cnt_reg[0] > len_eff) ? len_eff : cnt_reg[0];
    assign cand.id  = sel_id_reg;
    assign ins_en   = (state_reg == S_SEL) && ({1'b0, sel_id_reg} < entry_count_reg);

    assign cur       = cell_q[rank_reg];
    assign rank_hit  = ({1'b0, rank_reg} < found_reg);
    assign rank_last = ({1'b0, rank_reg} == (k_eff - 4'd1));

    assign div_req.start = (state_reg == S_OUT) && rank_hit;
    assign div_req.num   = len_eff - cur.cnt;
    assign div_req.den   = len_eff;

    // ranking chain, cell 0 holds the best entry
    for (genvar j = 0; j < MAX_K; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            kci_cell u_cell (
                .clk       (clk),
                .en        (ins_en),
                .valid     (filled_reg > 4'(j)),
                .keep_prev (1'b1),
                .prev_ent  (cand),
                .cand      (cand),
                .keep      (keep[j]),
                .ent       (cell_q[j])
            );
        end
        else
        begin : g_body
            kci_cell u_cell (
                .clk       (clk),
                .en        (ins_en),
                .valid     (filled_reg > 4'(j)),
                .keep_prev (keep[j-1]),
                .prev_ent  (cell_q[j-1]),
                .cand      (cand),
                .keep      (keep[j]),
                .ent       (cell_q[j])
            );
        end
    end

    kci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = {pos_reg, val_reg, entry_count_reg[ID_W-1:ID_W-GRP_W]};
        mem_wd = mem_rd_reg | (LANES'(1) << entry_count_reg[ID_W-GRP_W-1:0]);
        mem_ra = {fragment_index, fragment_value[3:0],
                  opcode ? GRP_W'(0) : entry_count_reg[ID_W-1:ID_W-GRP_W]};
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
            end
            S_ADD_WR:
                mem_we = 1'b1;
            S_Q_UPD:
                mem_ra = {pos_reg, val_reg, grp_reg + GRP_W'(1)};
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_rd_reg <= mem[mem_ra];
    end

    // counter ring: turns one lane group per word on a query, one entry per cycle on ranking
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            cnt_next[i] = cnt_reg[i];
        case (state_reg)
            S_Q_UPD:
            begin
                for (int i = 0; i < MAX_ENTRIES - LANES; i++)
                    cnt_next[i] = cnt_reg[i + LANES];
                for (int j = 0; j < LANES; j++)
                begin
                    if (mem_rd_reg[j] && ({1'b0, grp_reg, 6'(j)} < entry_count_reg) &&
                        (cnt_reg[j] != {CNT_W{1'b1}}))
                        cnt_next[MAX_ENTRIES - LANES + j] = cnt_reg[j] + CNT_W'(1);
                    else
                        cnt_next[MAX_ENTRIES - LANES + j] = cnt_reg[j];
                end
            end
            S_SEL:
            begin
                for (int i = 0; i < MAX_ENTRIES - 1; i++)
                    cnt_next[i] = cnt_reg[i + 1];
                cnt_next[MAX_ENTRIES - 1] = '0;
            end
            default:
                cnt_next[0] = cnt_reg[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            entry_count_reg <= '0;
            code_length_reg <= 10'd512;
            nc_reg          <= 4'd4;
            filled_reg      <= '0;
            grp_reg         <= '0;
            sel_id_reg      <= '0;
            rank_reg        <= '0;
            found_reg       <= '0;
            rv_reg          <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CODE_LENGTH:     code_length_reg <= cfg_data;
                    CFG_NEIGHBOUR_COUNT: nc_reg          <= cfg_data[3:0];
                    default:             nc_reg          <= nc_reg;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == {ADDR_W{1'b1}})
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        pos_reg  <= fragment_index;
                        val_reg  <= fragment_value[3:0];
                        last_reg <= last_fragment;
                        grp_reg  <= '0;
                        if (!opcode)
                        begin
                            if (present && !full)
                                state_reg <= S_ADD_WR;
                            else if (last_fragment)
                            begin
                                rv_reg        <= 1'b1;
                                id_reg        <= full ? 9'h1ff : {1'b0, entry_count_reg[ID_W-1:0]};
                                rank_out_reg  <= '0;
                                cnt_out_reg   <= '0;
                                dist_reg      <= '0;
                                found_out_reg <= '0;
                                status_reg    <= full;
                                last_out_reg  <= 1'b1;
                                if (!full)
                                    entry_count_reg <= entry_count_reg + 9'd1;
                            end
                        end
                        else if (present)
                            state_reg <= S_Q_UPD;
                        else if (last_fragment)
                        begin
                            state_reg  <= S_SEL;
                            sel_id_reg <= '0;
                            filled_reg <= '0;
                        end
                    end
                end
                S_ADD_WR:
                begin
                    state_reg <= S_IDLE;
                    if (last_reg)
                    begin
                        rv_reg          <= 1'b1;
                        id_reg          <= {1'b0, entry_count_reg[ID_W-1:0]};
                        rank_out_reg    <= '0;
                        cnt_out_reg     <= '0;
                        dist_reg        <= '0;
                        found_out_reg   <= '0;
                        status_reg      <= 1'b0;
                        last_out_reg    <= 1'b1;
                        entry_count_reg <= entry_count_reg + 9'd1;
                    end
                end
                S_Q_UPD:
                begin
                    grp_reg <= grp_reg + GRP_W'(1);
                    if (grp_reg == {GRP_W{1'b1}})
                    begin
                        if (last_reg)
                        begin
                            state_reg  <= S_SEL;
                            sel_id_reg <= '0;
                            filled_reg <= '0;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_SEL:
                begin
                    sel_id_reg <= sel_id_reg + ID_W'(1);
                    if (ins_en && (filled_reg < 4'(MAX_K)))
                        filled_reg <= filled_reg + 4'd1;
                    if (sel_id_reg == {ID_W{1'b1}})
                    begin
                        state_reg <= S_OUT;
                        rank_reg  <= '0;
                        found_reg <= (entry_count_reg < {5'b0, k_eff}) ?
                                     entry_count_reg[3:0] : k_eff;
                    end
                end
                S_OUT:
                begin
                    if (rank_hit)
                        state_reg <= S_DIV;
                    else
                    begin
                        rv_reg        <= 1'b1;
                        id_reg        <= 9'h1ff;
                        rank_out_reg  <= rank_reg;
                        cnt_out_reg   <= '0;
                        dist_reg      <= 17'h10000;
                        found_out_reg <= found_reg;
                        status_reg    <= 1'b0;
                        last_out_reg  <= rank_last;
                        if (rank_last)
                            state_reg <= S_IDLE;
                        else
                            rank_reg <= rank_reg + 3'd1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        rv_reg        <= 1'b1;
                        id_reg        <= {1'b0, cur.id};
                        rank_out_reg  <= rank_reg;
                        cnt_out_reg   <= cur.cnt;
                        dist_reg      <= div_q;
                        found_out_reg <= found_reg;
                        status_reg    <= 1'b0;
                        last_out_reg  <= rank_last;
                        if (rank_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            rank_reg  <= rank_reg + 3'd1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = rv_reg;
    assign entry_id     = id_reg;
    assign rank         = rank_out_reg;
    assign match_count  = cnt_out_reg;
    assign distance_q16 = dist_reg;
    assign found_count  = found_out_reg;
    assign status       = status_reg;
    assign last_result  = last_out_reg;

endmodule

>>> rtl/kci_cell.sv
module kci_cell (
    input  logic              clk,
    input  logic              en,
    input  logic              valid,
    input  logic              keep_prev,
    input  kci_pkg::cell_ent_t prev_ent,
    input  kci_pkg::cell_ent_t cand,
    output logic              keep,
    output kci_pkg::cell_ent_t ent
);
    import kci_pkg::*;

    cell_ent_t ent_reg;

    // a held entry stays only if strictly better; ties let the later id in above it
    assign keep = valid && (ent_reg.cnt > cand.cnt);
    assign ent  = ent_reg;

    always_ff @(posedge clk)
    begin
        if (en && !keep)
        begin
            if (keep_prev)
                ent_reg <= cand;
            else
                ent_reg <= prev_ent;
        end
    end

endmodule

>>> rtl/kci_div.sv
module kci_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kci_pkg::div_req_t       req,
    output logic                    done,
    output logic [kci_pkg::Q_W-1:0] quot
);
    import kci_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    trial;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign done  = done_reg;
    assign quot  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dvd_reg  <= {req.num, 16'b0};
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= CNT_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[CNT_W-1:0];
                    quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
                end
                dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/kci_checker.sv
module kci_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              result_valid,
    input logic signed [8:0] entry_id,
    input logic [2:0]        rank,
    input logic [16:0]       distance_q16,
    input logic [3:0]        found_count,
    input logic              status,
    input logic              last_result
);

    // more results of the same operation follow, so the block stays occupied or shows the next one
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> busy || result_valid)
        else $error("block went idle inside a multi-result transaction");

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> (entry_id == 9'sh1ff) && last_result)
        else $error("store-full result carries an id");

    a_empty_rank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ({1'b0, rank} >= found_count) && (found_count != 4'd0) |->
        (entry_id == 9'sh1ff) && (distance_q16 == 17'h10000))
        else $error("rank past found count is not empty");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> distance_q16 <= 17'h10000)
        else $error("distance above one");

endmodule

bind keyframe_code_knn_index kci_checker u_kci_checker (.*);

>>> tb/tb_keyframe_code_knn_index.sv
module tb_keyframe_code_knn_index;
    import kci_pkg::*;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   SETTLE_CYCLES = 40;

    typedef struct {
        logic [8:0]  id;
        logic [2:0]  rnk;
        logic [9:0]  cnt;
        logic [16:0] dst;
        logic [3:0]  found;
        logic        stat;
        logic        last;
    } knn_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              opcode = 1'b0;
    logic [8:0]        fragment_index = '0;
    logic signed [4:0] fragment_value = '0;
    logic              last_fragment = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [9:0]        cfg_data = '0;
    logic              result_valid;
    logic signed [8:0] entry_id;
    logic [2:0]        rank;
    logic [9:0]        match_count;
    logic [16:0]       distance_q16;
    logic [3:0]        found_count;
    logic              status;
    logic              last_result;

    // shadow of the index
    bit [255:0]  member_bits [512][16];
    int unsigned entry_hits [256];
    int unsigned stored_entries;
    int unsigned code_len_reg;
    int unsigned k_reg;

    knn_result_t pending_results [$];
    int          errors;
    int          cycles;
    bit          no_gaps;

    keyframe_code_knn_index i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .fragment_index (fragment_index),
        .fragment_value (fragment_value),
        .last_fragment  (last_fragment),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .entry_id       (entry_id),
        .rank           (rank),
        .match_count    (match_count),
        .distance_q16   (distance_q16),
        .found_count    (found_count),
        .status         (status),
        .last_result    (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned eff_len();
        if (code_len_reg == 0) return 1;
        if (code_len_reg > CODE_LENGTH_MAX) return CODE_LENGTH_MAX;
        return code_len_reg;
    endfunction

    function automatic int unsigned eff_k();
        if (k_reg == 0) return 1;
        if (k_reg > MAX_K) return MAX_K;
        return k_reg;
    endfunction

    task automatic predict_fragment(logic op, logic [8:0] pos, logic [4:0] raw, logic last);
        int unsigned len;
        bit          present;
        bit          full;
        bit          taken [256];
        int          best;
        int unsigned best_s;
        int unsigned s;
        int unsigned k;
        int unsigned found;
        knn_result_t r;
        len = eff_len();
        present = (raw < FRAGMENT_DIM) && (pos < len);
        if (op == OP_ADD)
        begin
            full = stored_entries >= MAX_ENTRIES;
            if (present && !full)
                member_bits[pos][raw[3:0]][stored_entries] = 1'b1;
            if (!last)
                return;
            r = '{id: full ? 9'h1FF : 9'(stored_entries), rnk: 0, cnt: 0, dst: 0,
                  found: 0, stat: full, last: 1'b1};
            pending_results = {pending_results, r};
            if (!full)
                stored_entries++;
            return;
        end
        if (present)
            for (int i = 0; i < stored_entries; i++)
                if (member_bits[pos][raw[3:0]][i] && entry_hits[i] < 1023)
                    entry_hits[i]++;
        if (!last)
            return;
        k = eff_k();
        found = (stored_entries < k) ? stored_entries : k;
        foreach (taken[i])
            taken[i] = 1'b0;
        for (int unsigned rk = 0; rk < k; rk++)
        begin
            if (rk < found)
            begin
                // highest count first, ties to the higher id
                best = -1;
                best_s = 0;
                for (int i = 0; i < stored_entries; i++)
                begin
                    s = (entry_hits[i] > len) ? len : entry_hits[i];
                    if (!taken[i] && (best < 0 || s >= best_s))
                    begin
                        best = i;
                        best_s = s;
                    end
                end
                taken[best] = 1'b1;
                r = '{id: 9'(best), rnk: 3'(rk), cnt: 10'(best_s),
                      dst: 17'((longint'(len - best_s) * 65536) / len),
                      found: 4'(found), stat: 1'b0, last: rk + 1 == k};
            end
            else
            begin
                r = '{id: 9'h1FF, rnk: 3'(rk), cnt: 0, dst: 17'd65536,
                      found: 4'(found), stat: 1'b0, last: rk + 1 == k};
            end
            pending_results = {pending_results, r};
        end
        foreach (entry_hits[i])
            entry_hits[i] = 0;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        knn_result_t e;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                e = pending_results.pop_front();
                if (entry_id !== e.id)
                    report_mismatch($sformatf("entry_id %0d exp %0d", entry_id, $signed(e.id)));
                if (rank !== e.rnk)
                    report_mismatch($sformatf("rank %0d exp %0d", rank, e.rnk));
                if (match_count !== e.cnt)
                    report_mismatch($sformatf("match_count %0d exp %0d", match_count, e.cnt));
                if (distance_q16 !== e.dst)
                    report_mismatch($sformatf("distance %0d exp %0d", distance_q16, e.dst));
                if (found_count !== e.found)
                    report_mismatch($sformatf("found_count %0d exp %0d", found_count, e.found));
                if (status !== e.stat)
                    report_mismatch($sformatf("status %0d exp %0d", status, e.stat));
                if (last_result !== e.last)
                    report_mismatch($sformatf("last_result %0d exp %0d", last_result, e.last));
            end
        end
    end

    // one fragment transaction; start stays high if the next one follows at once
    task automatic send_fragment(logic op, logic [8:0] pos, logic signed [4:0] val,
                                 logic last);
        int gap;
        gap = (!no_gaps && $urandom_range(99) < 23) ? $urandom_range(4, 1) : 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        opcode         <= op;
        fragment_index <= pos;
        fragment_value <= val;
        last_fragment  <= last;
        do
            @(posedge clk);
        while (busy);
        predict_fragment(op, pos, val, last);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [9:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CODE_LENGTH)
            code_len_reg = value;
        else
            k_reg = value[3:0];
    endtask

    task automatic test_defaults_and_extremes();
        send_fragment(OP_QUERY, 9'd0, 5'sd0, 1'b1);
        send_fragment(OP_ADD, 9'd0, 5'sd15, 1'b0);
        send_fragment(OP_ADD, 9'd511, 5'sd0, 1'b0);
        send_fragment(OP_ADD, 9'd5, -5'sd1, 1'b0);
        send_fragment(OP_ADD, 9'd6, -5'sd16, 1'b1);
        send_fragment(OP_ADD, 9'd0, 5'sd15, 1'b1);
        send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b0);
        send_fragment(OP_QUERY, 9'd511, 5'sd0, 1'b0);
        send_fragment(OP_QUERY, 9'd5, -5'sd16, 1'b1);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_CODE_LENGTH, 10'd1);
        write_reg(CFG_NEIGHBOUR_COUNT, 10'd1);
        send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b0);
        send_fragment(OP_QUERY, 9'd1, 5'sd0, 1'b1);
        write_reg(CFG_CODE_LENGTH, 10'd0);
        write_reg(CFG_NEIGHBOUR_COUNT, 10'd0);
        send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b1);
        write_reg(CFG_CODE_LENGTH, 10'd1023);
        write_reg(CFG_NEIGHBOUR_COUNT, 10'd15);
        send_fragment(OP_QUERY, 9'd511, 5'sd0, 1'b1);
        // repeated positions push the count past the code length
        write_reg(CFG_CODE_LENGTH, 10'd3);
        write_reg(CFG_NEIGHBOUR_COUNT, 10'd8);
        repeat (5)
            send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b0);
        send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b1);
        // add left open while a query runs
        send_fragment(OP_ADD, 9'd0, 5'sd15, 1'b0);
        send_fragment(OP_QUERY, 9'd0, 5'sd15, 1'b1);
        send_fragment(OP_ADD, 9'd1, 5'sd3, 1'b1);
    endtask

    task automatic test_random_codes();
        int          items;
        int          len;
        logic        op;
        logic [8:0]  pos;
        logic signed [4:0] val;
        int unsigned lim;
        items = 0;
        while (items < 180)
        begin
            if (items % 30 == 0)
            begin
                case ($urandom_range(4))
                    0: write_reg(CFG_CODE_LENGTH, 10'd512);
                    1: write_reg(CFG_CODE_LENGTH, 10'd1);
                    default: write_reg(CFG_CODE_LENGTH, 10'($urandom_range(16, 4)));
                endcase
                write_reg(CFG_NEIGHBOUR_COUNT, 10'($urandom_range(8, 1)));
            end
            no_gaps = items >= 60 && items < 110;
            op = ($urandom_range(99) < 45) ? OP_ADD : OP_QUERY;
            len = $urandom_range(6, 1);
            lim = eff_len();
            for (int f = 0; f < len; f++)
            begin
                if ($urandom_range(99) < 85)
                begin
                    pos = 9'($urandom_range(lim > 6 ? 5 : lim - 1));
                    val = 5'($urandom_range(3));
                end
                else
                begin
                    pos = 9'($urandom);
                    val = 5'($urandom);
                end
                if ($urandom_range(99) < 5)
                begin
                    send_fragment(~op, pos, val, 1'b0);
                    items++;
                end
                send_fragment(op, pos, val, f == len - 1);
                items++;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_store_full();
        write_reg(CFG_CODE_LENGTH, 10'd16);
        write_reg(CFG_NEIGHBOUR_COUNT, 10'd8);
        while (stored_entries < MAX_ENTRIES)
            send_fragment(OP_ADD, 9'($urandom_range(15)), 5'($urandom_range(15)), 1'b1);
        send_fragment(OP_ADD, 9'd2, 5'sd2, 1'b0);
        send_fragment(OP_ADD, 9'd3, 5'sd2, 1'b1);
        send_fragment(OP_QUERY, 9'd2, 5'sd2, 1'b0);
        send_fragment(OP_QUERY, 9'd3, 5'sd1, 1'b1);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        no_gaps = 1'b0;
        stored_entries = 0;
        code_len_reg = 512;
        k_reg = 4;
        foreach (entry_hits[i])
            entry_hits[i] = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults_and_extremes();
        test_config_extremes();
        test_random_codes();
        test_store_full();
        drain_results();
        repeat (600)
            @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
